FILE: src/fpa_pkg.sv
// Fixed-point ALU package: opcode codes, pipeline item kinds and the control
// group that travels with an item along the cell chain. No dependencies.
`default_nettype none

package fpa_pkg;

	localparam int unsigned OP_BITS  = 4;
	localparam int unsigned IO_BITS  = 32;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD        = 4'd0,
		OP_SUB        = 4'd1,
		OP_MUL        = 4'd2,
		OP_DIV        = 4'd3,
		OP_EQ         = 4'd4,
		OP_NE         = 4'd5,
		OP_GT         = 4'd6,
		OP_LT         = 4'd7,
		OP_GE         = 4'd8,
		OP_LE         = 4'd9,
		OP_MIN        = 4'd10,
		OP_MAX        = 4'd11,
		OP_INC        = 4'd12,
		OP_DEC        = 4'd13,
		OP_INT_TO_FIX = 4'd14,
		OP_FIX_TO_INT = 4'd15
	} op_t;

	// What each cell does with an item
	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_MUL  = 2'd1,
		KIND_DIV  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  neg;
		logic  flag;
		logic  dz;
	} ctl_t;

endpackage

`default_nettype wire

FILE: src/fpa_if.sv
// Valid/ready channel interfaces for the fixed-point ALU request and response.
// Depends on fpa_pkg for the payload widths.
`default_nettype none

interface fpa_req_if;
	import fpa_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [OP_BITS-1:0]         op;
	logic signed [IO_BITS-1:0]  a;
	logic signed [IO_BITS-1:0]  b;

	modport source (output valid, output op, output a, output b, input ready);
	modport sink   (input valid, input op, input a, input b, output ready);
endinterface

interface fpa_rsp_if;
	import fpa_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [IO_BITS-1:0]  value;
	logic                       flag;
	logic                       div_zero;

	modport source (output valid, output value, output flag, output div_zero, input ready);
	modport sink   (input valid, input value, input flag, input div_zero, output ready);
endinterface

`default_nettype wire

FILE: src/fpa_decode.sv
// Front decode of the fixed-point ALU: wraps operands to the word, computes
// the pass-through ops directly and loads the initial cell state for mul and div. Uses fpa_pkg.
`default_nettype none

module fpa_decode #(
	parameter int unsigned WORD_BITS = 32,
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire logic [fpa_pkg::OP_BITS-1:0]         op,
	input  wire logic signed [fpa_pkg::IO_BITS-1:0]  a,
	input  wire logic signed [fpa_pkg::IO_BITS-1:0]  b,
	output fpa_pkg::ctl_t                            ctl,
	output logic [WORD_BITS+FRAC_BITS-1:0]           acc,
	output logic [WORD_BITS+FRAC_BITS-1:0]           num,
	output logic [WORD_BITS+FRAC_BITS-1:0]           opd,
	output logic [WORD_BITS-1:0]                     rem
);
	import fpa_pkg::*;

	localparam int unsigned N = WORD_BITS + FRAC_BITS;

	logic signed [63:0]          a64;
	logic signed [63:0]          b64;
	logic signed [WORD_BITS-1:0] aw;
	logic signed [WORD_BITS-1:0] bw;
	logic [WORD_BITS-1:0]        a_mag;
	logic [WORD_BITS-1:0]        b_mag;
	logic [WORD_BITS-1:0]        val;
	logic                        lt;
	logic                        gt;
	logic                        eq;

	assign a64   = 64'(a);
	assign b64   = 64'(b);
	assign aw    = a64[WORD_BITS-1:0];
	assign bw    = b64[WORD_BITS-1:0];
	assign a_mag = aw[WORD_BITS-1] ? WORD_BITS'(-aw) : WORD_BITS'(aw);
	assign b_mag = bw[WORD_BITS-1] ? WORD_BITS'(-bw) : WORD_BITS'(bw);
	assign lt    = aw < bw;
	assign gt    = bw < aw;
	assign eq    = aw == bw;

	always_comb begin
		val      = '0;
		ctl.kind = KIND_PASS;
		ctl.neg  = 1'b0;
		ctl.flag = 1'b0;
		ctl.dz   = 1'b0;
		num      = '0;
		opd      = '0;
		rem      = '0;
		unique case (op_t'(op))
			OP_ADD:        val = WORD_BITS'(aw + bw);
			OP_SUB:        val = WORD_BITS'(aw - bw);
			OP_MUL: begin
				ctl.kind = KIND_MUL;
				num      = N'(bw);
				opd      = N'(aw);
			end
			OP_DIV: begin
				if (bw == '0) begin
					ctl.dz = 1'b1;
				end else begin
					ctl.kind = KIND_DIV;
					ctl.neg  = aw[WORD_BITS-1] ^ bw[WORD_BITS-1];
					num      = N'(a_mag) << FRAC_BITS;
					opd      = N'(b_mag);
				end
			end
			OP_EQ:         ctl.flag = eq;
			OP_NE:         ctl.flag = !eq;
			OP_GT:         ctl.flag = gt;
			OP_LT:         ctl.flag = lt;
			OP_GE:         ctl.flag = !lt;
			OP_LE:         ctl.flag = !gt;
			OP_MIN:        val = lt ? aw : bw;
			OP_MAX:        val = gt ? aw : bw;
			OP_INC:        val = WORD_BITS'(aw + WORD_BITS'(1));
			OP_DEC:        val = WORD_BITS'(aw - WORD_BITS'(1));
			OP_INT_TO_FIX: val = WORD_BITS'(aw << FRAC_BITS);
			OP_FIX_TO_INT: val = WORD_BITS'(aw >>> FRAC_BITS);
		endcase
	end

	// Pass-through results ride in the same slice of acc where the product lands
	assign acc = (ctl.kind == KIND_MUL) ? '0 : (N'(val) << FRAC_BITS);

endmodule

`default_nettype wire

FILE: src/fpa_cell.sv
// One cell of the fixed-point ALU chain: one shift-add multiply step or one
// restoring divide step per item, or a plain pass, then a register. Uses fpa_pkg.
`default_nettype none

module fpa_cell #(
	parameter int unsigned WORD_BITS = 32,
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 prev_vld,
	input  wire fpa_pkg::ctl_t                        prev_ctl,
	input  wire logic [WORD_BITS+FRAC_BITS-1:0]       prev_acc,
	input  wire logic [WORD_BITS+FRAC_BITS-1:0]       prev_num,
	input  wire logic [WORD_BITS+FRAC_BITS-1:0]       prev_opd,
	input  wire logic [WORD_BITS-1:0]                 prev_rem,
	output logic                                      cur_vld,
	output fpa_pkg::ctl_t                             cur_ctl,
	output logic [WORD_BITS+FRAC_BITS-1:0]            cur_acc,
	output logic [WORD_BITS+FRAC_BITS-1:0]            cur_num,
	output logic [WORD_BITS+FRAC_BITS-1:0]            cur_opd,
	output logic [WORD_BITS-1:0]                      cur_rem
);
	import fpa_pkg::*;

	localparam int unsigned N = WORD_BITS + FRAC_BITS;

	logic [WORD_BITS:0]   r2;
	logic [WORD_BITS:0]   dvs;
	logic [WORD_BITS:0]   diff;
	logic                 ge;
	logic [N-1:0]         acc_n;
	logic [N-1:0]         num_n;
	logic [N-1:0]         opd_n;
	logic [WORD_BITS-1:0] rem_n;

	logic                 vld_q;
	ctl_t                 ctl_q;
	logic [N-1:0]         acc_q;
	logic [N-1:0]         num_q;
	logic [N-1:0]         opd_q;
	logic [WORD_BITS-1:0] rem_q;

	assign r2   = {prev_rem, prev_num[N-1]};
	assign dvs  = {1'b0, prev_opd[WORD_BITS-1:0]};
	assign ge   = r2 >= dvs;
	assign diff = r2 - dvs;

	always_comb begin
		acc_n = prev_acc;
		num_n = prev_num;
		opd_n = prev_opd;
		rem_n = prev_rem;
		unique case (prev_ctl.kind)
			KIND_MUL: begin
				// Add the shifted multiplicand for each set multiplier bit
				acc_n = prev_num[0] ? N'(prev_acc + prev_opd) : prev_acc;
				num_n = prev_num >> 1;
				opd_n = prev_opd << 1;
			end
			KIND_DIV: begin
				// Shift the next dividend bit into the remainder, quotient bit in at the bottom
				rem_n = ge ? diff[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
				num_n = {prev_num[N-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q <= prev_ctl;
			acc_q <= acc_n;
			num_q <= num_n;
			opd_q <= opd_n;
			rem_q <= rem_n;
		end
	end

	assign cur_vld = vld_q;
	assign cur_ctl = ctl_q;
	assign cur_acc = acc_q;
	assign cur_num = num_q;
	assign cur_opd = opd_q;
	assign cur_rem = rem_q;

endmodule

`default_nettype wire

FILE: src/fixed_point_alu_core.sv
// Fixed-point ALU top level: decode, a chain of WORD_BITS+FRAC_BITS cells and
// a response register. Depends on fpa_pkg, fpa_if, fpa_decode and fpa_cell.
// Throughput: one item per cycle while the response side is ready; each cell does one multiply or divide bit.
// Reset clears only the per-cell valid flags and the response valid.
`default_nettype none

module fixed_point_alu_core #(
	parameter int unsigned WORD_BITS = 32,
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);
	import fpa_pkg::*;

	// Chain depth: one cell per dividend bit, also one per multiplier bit
	localparam int unsigned N = WORD_BITS + FRAC_BITS;

	// Tap i is the input of cell i; tap N is the output of the last cell
	logic [N:0]           vld;
	logic [N:0]           en;
	ctl_t                 ctl_w [N+1];
	logic [N-1:0]         acc_w [N+1];
	logic [N-1:0]         num_w [N+1];
	logic [N-1:0]         opd_w [N+1];
	logic [WORD_BITS-1:0] rem_w [N+1];

	logic                 out_en;
	logic                 vld_q;
	logic signed [IO_BITS-1:0] value_q;
	logic                 flag_q;
	logic                 dz_q;
	logic [WORD_BITS-1:0] quo;
	logic [WORD_BITS-1:0] res;

	fpa_decode #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_decode (
		.op (req.op),
		.a  (req.a),
		.b  (req.b),
		.ctl(ctl_w[0]),
		.acc(acc_w[0]),
		.num(num_w[0]),
		.opd(opd_w[0]),
		.rem(rem_w[0])
	);

	assign vld[0] = req.valid;

	// A cell loads when it is empty or its own item moves on; bubbles collapse
	assign out_en = !vld_q || rsp.ready;
	assign en[N]  = out_en;

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign en[i] = !vld[i+1] || en[i+1];

		fpa_cell #(
			.WORD_BITS(WORD_BITS),
			.FRAC_BITS(FRAC_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en[i]),
			.prev_vld(vld[i]),
			.prev_ctl(ctl_w[i]),
			.prev_acc(acc_w[i]),
			.prev_num(num_w[i]),
			.prev_opd(opd_w[i]),
			.prev_rem(rem_w[i]),
			.cur_vld (vld[i+1]),
			.cur_ctl (ctl_w[i+1]),
			.cur_acc (acc_w[i+1]),
			.cur_num (num_w[i+1]),
			.cur_opd (opd_w[i+1]),
			.cur_rem (rem_w[i+1])
		);
	end

	assign req.ready = en[0];

	// Quotient magnitude sits in the low bits of num; apply the sign here.
	// Products and pass-through results share the acc slice above the fraction.
	assign quo = num_w[N][WORD_BITS-1:0];
	assign res = (ctl_w[N].kind == KIND_DIV) ? (ctl_w[N].neg ? WORD_BITS'(-quo) : quo)
	                                         : acc_w[N][N-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_en) begin
			vld_q <= vld[N];
		end
	end

	// Sign-extend a narrow word, keep the low 32 bits of a wide one
	always_ff @(posedge clk) begin
		if (out_en) begin
			value_q <= IO_BITS'($signed(res));
			flag_q  <= ctl_w[N].flag;
			dz_q    <= ctl_w[N].dz;
		end
	end

	assign rsp.valid    = vld_q;
	assign rsp.value    = value_q;
	assign rsp.flag     = flag_q;
	assign rsp.div_zero = dz_q;

endmodule

`default_nettype wire

FILE: dv/tb_fixed_point_alu_core.sv
// Testbench for fixed_point_alu_core: drives opcode/operand items into the
// request channel and checks every response against a Q24.8 predictor.
// Depends on fpa_pkg, fpa_if and the fixed_point_alu_core RTL.
`default_nettype none

module tb_fixed_point_alu_core;
	import fpa_pkg::*;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned FRAC_BITS = 8;

	// Cell chain length of the block at the default sizes, plus some slack
	localparam int DRAIN_CYCLES = WORD_BITS + FRAC_BITS + 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400_000;
	localparam int MAX_REPORTS  = 10;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

	// One response as the block should produce it, plus the request for messages
	typedef struct {
		op_t                op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic        [31:0] value;
		logic               flag;
		logic               div_zero;
	} alu_result_t;

	logic clk;
	logic arst_n;

	fpa_req_if req_ch ();
	fpa_rsp_if rsp_ch ();

	alu_result_t pending_results[$];
	int          mismatch_cnt  = 0;
	int          cycle_cnt     = 0;
	int          req_gap_pct   = 0;  // read only by the main process
	int          rsp_stall_pct = 0;  // written with NBA, read by the receiver
	int          hold_req      = 0;  // bump to request one long receiver hold-off

	fixed_point_alu_core #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Work out the single response of one request at WORD_BITS = 32.
	function automatic alu_result_t alu_predict(op_t op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_result_t r;
		longint      prod;
		longint      sa;
		longint      sb;
		logic [63:0] mag_a;
		logic [63:0] mag_b;
		logic [63:0] quo;
		r.op       = op;
		r.a        = a;
		r.b        = b;
		r.value    = '0;
		r.flag     = 1'b0;
		r.div_zero = 1'b0;
		sa = 64'(a);
		sb = 64'(b);
		case (op)
			OP_ADD: r.value = a + b;
			OP_SUB: r.value = a - b;
			OP_MUL: begin
				// full product, then arithmetic shift: rounds toward minus infinity
				prod = sa * sb;
				prod = prod >>> FRAC_BITS;
				r.value = prod[31:0];
			end
			OP_DIV: begin
				if (b == 0) begin
					r.div_zero = 1'b1;
				end else begin
					// unsigned divide of magnitudes truncates toward zero
					mag_a = (sa < 0) ? -sa : sa;
					mag_b = (sb < 0) ? -sb : sb;
					quo = (mag_a << FRAC_BITS) / mag_b;
					if ((sa < 0) != (sb < 0))
						quo = -quo;
					r.value = quo[31:0];
				end
			end
			OP_EQ:  r.flag = (a == b);
			OP_NE:  r.flag = (a != b);
			OP_GT:  r.flag = (a > b);
			OP_LT:  r.flag = (a < b);
			OP_GE:  r.flag = (a >= b);
			OP_LE:  r.flag = (a <= b);
			OP_MIN: r.value = (a < b) ? a : b;
			OP_MAX: r.value = (b < a) ? a : b;
			OP_INC: r.value = a + 32'sd1;
			OP_DEC: r.value = a - 32'sd1;
			OP_INT_TO_FIX: r.value = a <<< FRAC_BITS;
			default: r.value = a >>> FRAC_BITS;
		endcase
		return r;
	endfunction

	// Idle length: zero unless a pct-percent draw hits, then mostly short, a few long
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(16, 60);
		return $urandom_range(1, 3);
	endfunction

	// Operand mix: corners, small Q values, whole numbers and raw random bits
	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return Q_MIN;
			1: return Q_MAX;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sd0;
					1: return 32'sd1;
					2: return -32'sd1;
					default: return Q_ONE;
				endcase
			end
			3, 4: return $signed($urandom_range(0, 8191)) - 32'sd4096;
			5: return ($signed($urandom_range(0, 200)) - 32'sd100) <<< FRAC_BITS;
			default: return $signed($urandom());
		endcase
	endfunction

	// Offer one item and hold it until the block takes it. Valid stays high
	// across back-to-back items; it is dropped only when a gap is inserted.
	task automatic send_item(op_t op, logic signed [31:0] a, logic signed [31:0] b);
		int gap;
		gap = pick_gap(req_gap_pct);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.a     <= a;
		req_ch.b     <= b;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(alu_predict(op, a, b));
	endtask

	task automatic send_random_items(int count);
		for (int i = 0; i < count; i++)
			send_item(op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
	endtask

	// Corners of every op: wrap, rounding, truncation, divide by zero, ties
	task automatic test_directed_cases();
		send_item(OP_ADD, Q_MAX, 32'sd1);                 // wraps to most negative
		send_item(OP_SUB, Q_MIN, 32'sd1);                 // wraps to most positive
		send_item(OP_MUL, Q_MAX, Q_MAX);
		send_item(OP_MUL, Q_MIN, Q_MIN);
		send_item(OP_MUL, -32'sd1, 32'sd1);               // tiny negative rounds down
		send_item(OP_MUL, -32'sd3 <<< 7, 32'sd5 <<< 7);
		send_item(OP_DIV, 32'sd5 <<< FRAC_BITS, 32'sd0);  // divide by zero
		send_item(OP_DIV, Q_MIN, -Q_ONE);                 // most negative over -1 wraps
		send_item(OP_DIV, -32'sd3 <<< FRAC_BITS, 32'sd2 <<< FRAC_BITS);
		send_item(OP_DIV, Q_MAX, 32'sd1);
		send_item(OP_EQ, Q_MIN, Q_MIN);
		send_item(OP_NE, Q_MIN, Q_MAX);
		send_item(OP_GT, Q_MAX, Q_MIN);
		send_item(OP_LT, Q_MIN, Q_MAX);
		send_item(OP_GE, -32'sd1, -32'sd1);
		send_item(OP_LE, Q_MAX, Q_MIN);
		send_item(OP_MIN, 32'sd7, 32'sd7);                // equal operands
		send_item(OP_MAX, Q_MIN, -32'sd1);
		send_item(OP_INC, Q_MAX, Q_MIN);                  // b is ignored
		send_item(OP_DEC, Q_MIN, Q_MAX);
		send_item(OP_INT_TO_FIX, 32'sh00FF_FFFF, 32'sd9);
		send_item(OP_INT_TO_FIX, Q_MIN, 32'sd0);
		send_item(OP_FIX_TO_INT, -32'sd1, Q_MAX);
		send_item(OP_FIX_TO_INT, Q_MAX, -32'sd1);
	endtask

	// Full-rate stream with no idling on either side
	task automatic test_streaming();
		req_gap_pct = 0;
		rsp_stall_pct <= 0;
		send_random_items(150);
	endtask

	// Receiver parks for a long stretch while items keep coming
	task automatic test_back_pressure();
		req_gap_pct = 0;
		rsp_stall_pct <= 10;
		hold_req <= hold_req + 1;
		send_random_items(150);
	endtask

	// Random gaps on both sides, with the balance shifted between phases
	task automatic test_idle_mix();
		req_gap_pct = 30;
		rsp_stall_pct <= 30;
		send_random_items(170);
		req_gap_pct = 70;
		rsp_stall_pct <= 10;
		send_random_items(170);
		req_gap_pct = 10;
		rsp_stall_pct <= 70;
		send_random_items(170);
	endtask

	initial begin : main_seq
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op    = OP_ADD;
		req_ch.a     = '0;
		req_ch.b     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_streaming();
		test_back_pressure();
		test_idle_mix();

		// drop valid, drain the pipe, then allow stray results to show up
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off whenever hold_req moves.
	// The hold-off is counted here so the sender keeps offering meanwhile.
	initial begin : rsp_side
		int stall_left;
		int hold_seen;
		stall_left   = 0;
		hold_seen    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen  = hold_req;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = pick_gap(rsp_stall_pct);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted response with the oldest outstanding prediction
	always @(posedge clk) begin : check_results
		alu_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("unexpected response: value=%h flag=%b div_zero=%b",
						rsp_ch.value, rsp_ch.flag, rsp_ch.div_zero);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.value !== want.value || rsp_ch.flag !== want.flag ||
						rsp_ch.div_zero !== want.div_zero) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("%s a=%h b=%h: want %h/%b/%b got %h/%b/%b",
							want.op.name(), want.a, want.b,
							want.value, want.flag, want.div_zero,
							rsp_ch.value, rsp_ch.flag, rsp_ch.div_zero);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

`default_nettype wire
